[design/hgpv_pkg.sv]
// ----------------------------------------------------------------------------
// hgpv_pkg
// Shared types and constants for the head gesture peak/valley detector.
// ----------------------------------------------------------------------------
package hgpv_pkg;

    localparam int LEVEL_W = 13;
    localparam int INDEX_W = 32;
    localparam int SAMPLE_W = 16;

    // divide by 10: q = (|x| * 52429) >> 19, exact for |x| < 2^16
    localparam logic [15:0] DIV10_RECIP = 16'd52429;
    localparam int DIV10_SHIFT = 19;

    // configuration register indexes
    localparam logic [7:0] REG_GESTURE_MODE = 8'd0;
    localparam logic [7:0] REG_MIN_SPACING = 8'd1;
    localparam logic [7:0] REG_SWING_THRESHOLD = 8'd2;
    localparam logic [7:0] REG_PAIR_WINDOW = 8'd3;

    localparam logic [15:0] MIN_SPACING_RST = 16'd10;
    localparam logic [12:0] SWING_THRESHOLD_RST = 13'd20;
    localparam logic [15:0] PAIR_WINDOW_RST = 16'd20;

    typedef struct packed {
        logic                       falling_edge;
        logic                       minimum_found;
        logic                       maximum_found;
        logic signed [LEVEL_W-1:0]  minimum_level;
        logic signed [LEVEL_W-1:0]  maximum_level;
        logic signed [LEVEL_W-1:0]  previous_level;
        logic [INDEX_W-1:0]         minimum_position;
        logic [INDEX_W-1:0]         maximum_position;
    } tracker_t;

    // x axis tracker hunts a trough, second tracker hunts a peak
    localparam tracker_t TRK_X_INIT = '{
        falling_edge: 1'b0, minimum_found: 1'b0, maximum_found: 1'b1,
        minimum_level: 13'sd0, maximum_level: 13'sd0, previous_level: 13'sd0,
        minimum_position: 32'd0, maximum_position: 32'd0};

    localparam tracker_t TRK_O_INIT = '{
        falling_edge: 1'b0, minimum_found: 1'b1, maximum_found: 1'b0,
        minimum_level: 13'sd0, maximum_level: 13'sd0, previous_level: 13'sd10,
        minimum_position: 32'd0, maximum_position: 32'd0};

endpackage

[design/head_gesture_peak_valley_detector.sv]
// ----------------------------------------------------------------------------
// head_gesture_peak_valley_detector
// Nod/shake detector: trough on x paired with a peak on the second axis.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream: one word per sample pair: x sample, second-axis sample
//   (y for nod, z for shake, steered upstream) and a running index.
//   m_* stream: one word per input word with gesture / trough / peak flags.
//   cfg_* port: register writes (0 mode, 1 min_spacing, 2 swing_threshold,
//   3 pair_window). Any write to a known index restarts both trackers;
//   write only while the stream is idle. cfg_ready is always high.
// Timing:
//   Input is divided by 10 into a level register, then both trackers and
//   the pairing test update state and load the result register together.
//   Throughput is one word per clock while the result side is not stalled,
//   set by the tracker feedback loop.
// Reset / stall:
//   rst_n restores register defaults and tracker start state, and empties
//   the pipe. When m_tready is low the result holds, the level register
//   still fills, and s_tready drops once both stages are full.
// ----------------------------------------------------------------------------
module head_gesture_peak_valley_detector
    import hgpv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // s_tdata: [15:0] sample_x, [31:16] sample_other, [63:32] sample_index
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,
    // m_tdata: [0] gesture_detected, [1] trough_armed, [2] peak_armed, rest 0
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0]               min_spacing_reg;
    logic [12:0]               swing_threshold_reg;
    logic [15:0]               pair_window_reg;

    logic                      s1_valid_reg;
    logic signed [LEVEL_W-1:0] lvl_x_reg;
    logic signed [LEVEL_W-1:0] lvl_o_reg;
    logic [INDEX_W-1:0]        idx_reg;
    logic signed [LEVEL_W-1:0] lvl_x_next;
    logic signed [LEVEL_W-1:0] lvl_o_next;

    tracker_t                  trk_x_reg;
    tracker_t                  trk_o_reg;
    tracker_t                  trk_x_step;
    tracker_t                  trk_o_step;
    tracker_t                  trk_x_next;
    tracker_t                  trk_o_next;

    logic                      out_valid_reg;
    logic [2:0]                out_flags_reg;
    logic [2:0]                out_flags_next;

    logic                      s1_ready;
    logic                      advance;
    logic                      cfg_write;
    logic                      cfg_known;
    logic [INDEX_W-1:0]        dist_fwd;
    logic [INDEX_W-1:0]        dist_rev;
    logic [INDEX_W-1:0]        pair_dist;
    logic                      both_armed;
    logic                      paired;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    // mode has no effect on datapath here; its write only restarts trackers
    assign cfg_known = (cfg_index == REG_GESTURE_MODE) || (cfg_index == REG_MIN_SPACING) ||
                       (cfg_index == REG_SWING_THRESHOLD) || (cfg_index == REG_PAIR_WINDOW);

    assign s1_ready = !out_valid_reg || m_tready;
    assign advance  = s1_valid_reg && s1_ready;
    assign s_tready = !s1_valid_reg || s1_ready;

    hgpv_div10 u_div_x
    (
        .sample (s_tdata[15:0]),
        .level  (lvl_x_next)
    );

    hgpv_div10 u_div_o
    (
        .sample (s_tdata[31:16]),
        .level  (lvl_o_next)
    );

    hgpv_tracker u_trk_x
    (
        .state_cur       (trk_x_reg),
        .level           (lvl_x_reg),
        .index           (idx_reg),
        .min_spacing     (min_spacing_reg),
        .swing_threshold (swing_threshold_reg),
        .state_next      (trk_x_step)
    );

    hgpv_tracker u_trk_o
    (
        .state_cur       (trk_o_reg),
        .level           (lvl_o_reg),
        .index           (idx_reg),
        .min_spacing     (min_spacing_reg),
        .swing_threshold (swing_threshold_reg),
        .state_next      (trk_o_step)
    );

    // pairing: shorter way round the 2^32 index circle
    assign dist_fwd   = trk_x_step.minimum_position - trk_o_step.maximum_position;
    assign dist_rev   = 32'd0 - dist_fwd;
    assign pair_dist  = (dist_fwd < dist_rev) ? dist_fwd : dist_rev;
    assign both_armed = trk_x_step.minimum_found && trk_o_step.maximum_found;
    assign paired     = pair_dist < {16'd0, pair_window_reg};

    always_comb
    begin
        trk_x_next = trk_x_step;
        trk_o_next = trk_o_step;
        if (both_armed && !paired)
        begin
            trk_x_next.minimum_found = 1'b0;
            trk_o_next.maximum_found = 1'b0;
        end
        out_flags_next = {trk_o_next.maximum_found, trk_x_next.minimum_found,
                          both_armed && paired};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_spacing_reg     <= MIN_SPACING_RST;
            swing_threshold_reg <= SWING_THRESHOLD_RST;
            pair_window_reg     <= PAIR_WINDOW_RST;
            trk_x_reg           <= TRK_X_INIT;
            trk_o_reg           <= TRK_O_INIT;
            s1_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_write && cfg_known)
            begin
                trk_x_reg <= TRK_X_INIT;
                trk_o_reg <= TRK_O_INIT;
            end
            else if (advance)
            begin
                trk_x_reg <= trk_x_next;
                trk_o_reg <= trk_o_next;
            end

            if (cfg_write)
            begin
                case (cfg_index)
                    REG_MIN_SPACING:     min_spacing_reg     <= cfg_data;
                    REG_SWING_THRESHOLD: swing_threshold_reg <= cfg_data[12:0];
                    REG_PAIR_WINDOW:     pair_window_reg     <= cfg_data;
                    default:             ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            lvl_x_reg <= lvl_x_next;
            lvl_o_reg <= lvl_o_next;
            idx_reg   <= s_tdata[63:32];
        end
        if (advance)
        begin
            out_flags_reg <= out_flags_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_flags_reg};

    // gesture only reported with both extrema armed
    a_gesture_armed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[1] && m_tdata[2])
        else $error("gesture flagged without both extrema armed");

    // reported flags track the tracker state just loaded
    a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !cfg_write |=> m_tdata[1] == trk_x_reg.minimum_found &&
                                  m_tdata[2] == trk_o_reg.maximum_found)
        else $error("result flags differ from tracker state");

    // known register write restarts both trackers
    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write && cfg_known |=> trk_x_reg == TRK_X_INIT && trk_o_reg == TRK_O_INIT)
        else $error("trackers not restarted after register write");

    // level stage holds its word while the result side is stalled
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_ready |=> s1_valid_reg && $stable(idx_reg))
        else $error("level stage lost a word under stall");

endmodule

[design/hgpv_div10.sv]
// ----------------------------------------------------------------------------
// hgpv_div10
// Signed divide by 10, truncating toward zero, by reciprocal multiply.
// ----------------------------------------------------------------------------
module hgpv_div10
    import hgpv_pkg::*;
(
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic signed [LEVEL_W-1:0]  level
);

    logic [SAMPLE_W-1:0]   mag;
    logic [2*SAMPLE_W-1:0] prod;
    logic [LEVEL_W-1:0]    quot;

    // -(-32768) wraps to 16'h8000, which is right as an unsigned magnitude
    assign mag  = sample[SAMPLE_W-1] ? (~sample + 16'd1) : sample;
    assign prod = mag * DIV10_RECIP;
    assign quot = prod[DIV10_SHIFT +: LEVEL_W];
    assign level = sample[SAMPLE_W-1] ? $signed(~quot + 13'd1) : $signed(quot);

endmodule

[design/hgpv_tracker.sv]
// ----------------------------------------------------------------------------
// hgpv_tracker
// Next-state logic of one edge tracker with hysteresis on spacing and swing.
// ----------------------------------------------------------------------------
module hgpv_tracker
    import hgpv_pkg::*;
(
    input  tracker_t                   state_cur,
    input  logic signed [LEVEL_W-1:0]  level,
    input  logic [INDEX_W-1:0]         index,
    input  logic [15:0]                min_spacing,
    input  logic [12:0]                swing_threshold,
    output tracker_t                   state_next
);

    logic signed [LEVEL_W-1:0] prev;
    logic [INDEX_W-1:0]        gap_max;
    logic [INDEX_W-1:0]        gap_min;
    logic signed [LEVEL_W+1:0] swing_down;
    logic signed [LEVEL_W+1:0] swing_up;
    logic signed [LEVEL_W+1:0] thr;
    logic signed [LEVEL_W+1:0] prev_inc;
    logic                      far_max;
    logic                      far_min;

    assign prev     = state_cur.previous_level;
    assign gap_max  = index - state_cur.maximum_position;
    assign gap_min  = index - state_cur.minimum_position;
    assign far_max  = gap_max > {16'd0, min_spacing};
    assign far_min  = gap_min > {16'd0, min_spacing};
    assign thr      = $signed({2'b00, swing_threshold});
    assign swing_down = {{2{state_cur.maximum_level[LEVEL_W-1]}}, state_cur.maximum_level}
                      - {{2{prev[LEVEL_W-1]}}, prev};
    assign swing_up = {{2{prev[LEVEL_W-1]}}, prev}
                    - {{2{state_cur.minimum_level[LEVEL_W-1]}}, state_cur.minimum_level};
    assign prev_inc = {{2{prev[LEVEL_W-1]}}, prev} + 15'sd1;

    always_comb
    begin
        state_next = state_cur;
        if (level > prev)
        begin
            if (state_cur.falling_edge)
            begin
                state_next.falling_edge = 1'b0;
                if (state_cur.maximum_found)
                begin
                    if (far_max && (swing_down >= thr))
                    begin
                        state_next.minimum_found    = 1'b1;
                        state_next.maximum_found    = 1'b0;
                        state_next.minimum_position = index;
                        state_next.minimum_level    = prev;
                    end
                end
                else if (prev <= state_cur.minimum_level)
                begin
                    state_next.minimum_level    = prev;
                    state_next.minimum_position = index;
                end
            end
        end
        else if (level < prev)
        begin
            if (!state_cur.falling_edge)
            begin
                state_next.falling_edge = 1'b1;
                if (state_cur.minimum_found)
                begin
                    if (far_min && (swing_up >= thr))
                    begin
                        state_next.minimum_found    = 1'b0;
                        state_next.maximum_found    = 1'b1;
                        state_next.maximum_position = index;
                        state_next.maximum_level    = prev;
                    end
                end
                else if (prev_inc >= $signed({{2{state_cur.maximum_level[LEVEL_W-1]}},
                                              state_cur.maximum_level}))
                begin
                    state_next.maximum_level    = prev;
                    state_next.maximum_position = index;
                end
            end
        end
        else
        begin
            // flat sample: refine whichever extremum it touches
            if (level >= state_cur.maximum_level)
            begin
                state_next.maximum_level    = prev;
                state_next.maximum_position = index;
            end
            else if (level <= state_cur.minimum_level)
            begin
                state_next.minimum_level    = prev;
                state_next.minimum_position = index;
            end
        end
        state_next.previous_level = level;
    end

endmodule
